### design/ttceb_pkg.sv
// ----------------------------------------------------------------------------
// ttceb_pkg
// shared types, register codes and the elaboration-time cosine generator
// ----------------------------------------------------------------------------
package ttceb_pkg;

	localparam int IDX_W   = 10;
	localparam int RNG_W   = 16;
	localparam int SPD_W   = 16;
	localparam int COS_W   = 16;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int CFG_W   = 16;

	// shared multiplier operand and product widths
	localparam int MUL_AW  = 17;
	localparam int MUL_BW  = 31;
	localparam int MUL_PW  = MUL_AW + MUL_BW;

	// register indexes
	localparam logic [1:0] REG_TTC = 2'd0;
	localparam logic [1:0] REG_MAX = 2'd1;
	localparam logic [1:0] REG_MIN = 2'd2;

	// input operation codes
	localparam logic OP_SPEED = 1'b0;
	localparam logic OP_BEAM  = 1'b1;

	localparam logic [63:0] TWO_PI_URAD   = 64'd6283185;
	localparam logic [63:0] PI_URAD_FLOOR = 64'd3141592;
	localparam logic [63:0] PI_URAD_CEIL  = 64'd3141593;
	localparam logic [63:0] HALF_PI_URAD  = 64'd1570796;
	localparam logic [63:0] URAD_PER_RAD  = 64'd1000000;
	localparam logic [63:0] COS_DIV [7]   = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182};

	typedef struct packed {
		logic [CFG_W-1:0] ttc;
		logic [CFG_W-1:0] max_range;
		logic [CFG_W-1:0] min_range;
	} cfg_t;

	// cosine in signed Q1.14 of idx * step microradians, taylor series in Q30
	// only evaluated while building the rom at elaboration
	function automatic logic signed [COS_W-1:0] cos_q14(input int unsigned idx,
		input int unsigned step);
		logic [63:0]        a;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        q;
		logic               neg;
		a   = (64'(idx) * 64'(step)) % TWO_PI_URAD;
		neg = 1'b0;
		if (a > PI_URAD_FLOOR) begin
			a = TWO_PI_URAD - a;
		end
		if (a > HALF_PI_URAD) begin
			a   = PI_URAD_CEIL - a;
			neg = 1'b1;
		end
		x    = (a << 30) / URAD_PER_RAD;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = signed'(term);
		for (int k = 0; k < 7; k++) begin
			term = ((term * x2) >> 30) / COS_DIV[k];
			if ((k % 2) == 0) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		q = (unsigned'(sum) + 64'd32768) >> 16;
		return neg ? -signed'(q[COS_W-1:0]) : signed'(q[COS_W-1:0]);
	endfunction

endpackage

### design/ttceb_if.sv
// ----------------------------------------------------------------------------
// ttceb channel interfaces
// valid/ready channels for beam/speed items and brake results
// ----------------------------------------------------------------------------
interface ttceb_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] speed;
	logic [9:0]  beam_index;
	logic [15:0] range;
	logic        last_beam;

	modport source (output valid, op, speed, beam_index, range, last_beam, input ready);
	modport sink (input valid, op, speed, beam_index, range, last_beam, output ready);
endinterface

interface ttceb_out_if;
	logic        valid;
	logic        ready;
	logic        brake;
	logic [9:0]  hit_index;
	logic [15:0] hit_range;

	modport source (output valid, brake, hit_index, hit_range, input ready);
	modport sink (input valid, brake, hit_index, hit_range, output ready);
endinterface

### design/ttc_emergency_brake.sv
// ----------------------------------------------------------------------------
// ttc_emergency_brake
// time-to-collision emergency brake check over a stream of range beams
// ----------------------------------------------------------------------------
// items carries speed updates (op 0) and beams (op 1); results carries one
// transaction per beam that requests braking (first qualifying beam of a scan).
// registers sit on the apb port: ttc threshold at 0x0, max range at 0x4,
// min range at 0x8, writes complete in the access cycle, pready always high.
// a speed update is stored when accepted. a beam goes from acceptance to the
// result register through rom read, closing-rate multiply, threshold multiply
// and compare, both multiplies on one shared multiplier, one beam at a time.
// ready is high only while the sequencer is idle.
// one finished result can wait in the output register; the sequencer only
// stalls at its compare step if a new hit finds that register still full.
// reset clears the speed to zero, the scan flag, the output register and
// loads the register reset values (threshold 0, max 65535, min 0).
// ----------------------------------------------------------------------------
module ttc_emergency_brake #(
	parameter int WINDOW_START    = 450,
	parameter int WINDOW_END      = 630,
	parameter int ANGLE_STEP_URAD = 5818
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ttceb_in_if.sink                     items,
	ttceb_out_if.source                  results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ttceb_pkg::APB_AW-1:0] paddr,
	input  logic [ttceb_pkg::APB_DW-1:0] pwdata,
	output logic [ttceb_pkg::APB_DW-1:0] prdata,
	output logic                         pready
);
	import ttceb_pkg::*;

	localparam int ROM_DEPTH = WINDOW_END - WINDOW_START;
	localparam int ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_DONE
	} state_t;

	state_t                   state_q;
	cfg_t                     cfg;
	logic signed [SPD_W-1:0]  speed_q;
	logic                     triggered_q;
	logic                     qual_q;
	logic                     closing_pos_q;
	logic                     last_q;
	logic [IDX_W-1:0]         idx_q;
	logic [RNG_W-1:0]         rng_q;
	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic [RNG_W-1:0]         out_rng_q;

	logic                     accept;
	logic                     beam_acc;
	logic                     in_win;
	logic                     in_rng;
	logic [IDX_W-1:0]         idx_off;
	logic signed [COS_W-1:0]  cos_val;
	logic                     mul_en;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] prod;
	logic                     hit;
	logic                     can_load;

	ttceb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid & items.ready;
	assign beam_acc    = accept & (items.op == OP_BEAM);

	assign in_win  = ({1'b0, items.beam_index} >= (IDX_W+1)'(WINDOW_START))
		&& ({1'b0, items.beam_index} < (IDX_W+1)'(WINDOW_END));
	assign in_rng  = (items.range <= cfg.max_range) && (items.range >= cfg.min_range)
		&& (items.range != '0);
	assign idx_off = items.beam_index - IDX_W'(WINDOW_START);

	ttceb_cos_rom #(
		.WINDOW_START    (WINDOW_START),
		.DEPTH           (ROM_DEPTH),
		.ANGLE_STEP_URAD (ANGLE_STEP_URAD),
		.AW              (ROM_AW)
	) u_rom (
		.clk   (clk),
		.rd_en (beam_acc & in_win),
		.addr  (idx_off[ROM_AW-1:0]),
		.data  (cos_val)
	);

	// first pass: closing = -speed * cos, second pass: ttc * closing
	always_comb begin
		mul_en = 1'b0;
		mul_a  = -MUL_AW'(speed_q);
		mul_b  = MUL_BW'(cos_val);
		if (state_q == S_MUL1) begin
			mul_en = 1'b1;
		end else if (state_q == S_MUL2) begin
			mul_en = 1'b1;
			mul_a  = signed'({1'b0, cfg.ttc});
			mul_b  = prod[MUL_BW-1:0];
		end
	end

	ttceb_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// range in Q22 against threshold times closing rate
	assign hit      = qual_q && closing_pos_q
		&& (MUL_PW'({rng_q, 22'b0}) < unsigned'(prod));
	assign can_load = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			speed_q       <= '0;
			triggered_q   <= 1'b0;
			qual_q        <= 1'b0;
			closing_pos_q <= 1'b0;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_DONE && hit && can_load) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (items.op == OP_SPEED) begin
							speed_q <= signed'(items.speed);
						end else begin
							qual_q  <= !triggered_q && in_win && in_rng;
							last_q  <= items.last_beam;
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					closing_pos_q <= !prod[MUL_PW-1] && (prod != '0);
					state_q       <= S_DONE;
				end
				S_DONE: begin
					if (!hit || can_load) begin
						if (last_q) begin
							triggered_q <= 1'b0;
						end else if (hit) begin
							triggered_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// beam payload and result payload
	always_ff @(posedge clk) begin
		if (beam_acc) begin
			idx_q <= items.beam_index;
			rng_q <= items.range;
		end
		if (state_q == S_DONE && hit && can_load) begin
			out_idx_q <= idx_q;
			out_rng_q <= rng_q;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.brake     = 1'b1;
	assign results.hit_index = out_idx_q;
	assign results.hit_range = out_rng_q;

endmodule

### design/ttceb_regs.sv
// ----------------------------------------------------------------------------
// ttceb_regs
// apb configuration registers: ttc threshold, max range, min range
// ----------------------------------------------------------------------------
module ttceb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ttceb_pkg::APB_AW-1:0] paddr,
	input  logic [ttceb_pkg::APB_DW-1:0] pwdata,
	output logic [ttceb_pkg::APB_DW-1:0] prdata,
	output logic                         pready,
	output ttceb_pkg::cfg_t              cfg
);
	import ttceb_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ttc       <= '0;
			cfg_q.max_range <= '1;
			cfg_q.min_range <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TTC: cfg_q.ttc       <= pwdata[CFG_W-1:0];
				REG_MAX: cfg_q.max_range <= pwdata[CFG_W-1:0];
				REG_MIN: cfg_q.min_range <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TTC: prdata = APB_DW'(cfg_q.ttc);
			REG_MAX: prdata = APB_DW'(cfg_q.max_range);
			REG_MIN: prdata = APB_DW'(cfg_q.min_range);
			default: prdata = '0;
		endcase
	end

endmodule

### design/ttceb_cos_rom.sv
// ----------------------------------------------------------------------------
// ttceb_cos_rom
// cosine rom over the beam window, Q1.14 entries, registered read
// ----------------------------------------------------------------------------
module ttceb_cos_rom #(
	parameter int WINDOW_START    = 450,
	parameter int DEPTH           = 180,
	parameter int ANGLE_STEP_URAD = 5818,
	parameter int AW              = 8
) (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [AW-1:0]                       addr,
	output logic signed [ttceb_pkg::COS_W-1:0] data
);
	import ttceb_pkg::*;

	logic signed [COS_W-1:0] rom_w [DEPTH];
	logic signed [COS_W-1:0] data_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		localparam logic signed [COS_W-1:0] Entry =
			cos_q14(unsigned'(WINDOW_START + i), unsigned'(ANGLE_STEP_URAD));
		assign rom_w[i] = Entry;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= rom_w[addr];
		end
	end

	assign data = data_q;

endmodule

### design/ttceb_mul.sv
// ----------------------------------------------------------------------------
// ttceb_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module ttceb_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [ttceb_pkg::MUL_AW-1:0] a,
	input  logic signed [ttceb_pkg::MUL_BW-1:0] b,
	output logic signed [ttceb_pkg::MUL_PW-1:0] prod
);
	import ttceb_pkg::*;

	logic signed [MUL_PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MUL_PW'(a) * MUL_PW'(b);
		end
	end

	assign prod = prod_q;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks ttc_emergency_brake against its own brake predictor: speed updates and
// beam scans go in with random idling on both channels, each brake transaction
// is compared with the oldest predicted hit, registers are swept between phases
// ----------------------------------------------------------------------------
module tb_top;
	import ttceb_pkg::*;

	localparam int WIN_LO    = 450;
	localparam int WIN_HI    = 630;
	localparam int STEP_URAD = 5818;
	localparam int DRAIN_CYC = 12;

	typedef struct packed {
		logic             op;
		logic [SPD_W-1:0] speed;
		logic [IDX_W-1:0] idx;
		logic [RNG_W-1:0] rng;
		logic             last;
	} beam_item_t;

	typedef struct packed {
		logic             brake;
		logic [IDX_W-1:0] idx;
		logic [RNG_W-1:0] rng;
	} brake_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	ttceb_in_if  beam_ch();
	ttceb_out_if brake_ch();

	ttc_emergency_brake #(
		.WINDOW_START   (WIN_LO),
		.WINDOW_END     (WIN_HI),
		.ANGLE_STEP_URAD(STEP_URAD)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (beam_ch.sink),
		.results(brake_ch.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and register mirror
	logic signed [SPD_W-1:0] cur_speed;
	logic                    scan_hit;
	logic [CFG_W-1:0]        cfg_ttc;
	logic [CFG_W-1:0]        cfg_max;
	logic [CFG_W-1:0]        cfg_min;

	brake_t pending_brakes[$];
	brake_t want;
	int     err_count;
	bit     steady;

	task automatic note_mismatch(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// cosine of idx * step in q14, taylor series in q30 folded to the first quadrant
	function automatic longint beam_cosine(input logic [IDX_W-1:0] idx);
		longint unsigned ang;
		longint unsigned xq;
		longint unsigned xsq;
		longint unsigned t;
		longint          acc;
		longint          q;
		bit              flip;
		ang  = (64'(idx) * 64'(STEP_URAD)) % TWO_PI_URAD;
		flip = 1'b0;
		if (ang > PI_URAD_FLOOR) begin
			ang = TWO_PI_URAD - ang;
		end
		if (ang > HALF_PI_URAD) begin
			ang  = PI_URAD_CEIL - ang;
			flip = 1'b1;
		end
		xq  = (ang << 30) / URAD_PER_RAD;
		xsq = (xq * xq) >> 30;
		t   = 64'd1 << 30;
		acc = longint'(t);
		for (int k = 1; k <= 7; k++) begin
			t = ((t * xsq) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				acc = acc - longint'(t);
			end else begin
				acc = acc + longint'(t);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		q = (acc + 32768) >>> 16;
		return flip ? -q : q;
	endfunction

	task automatic predict_brake(input beam_item_t it);
		longint closing;
		brake_t hit;
		if (it.op == OP_SPEED) begin
			cur_speed = signed'(it.speed);
		end else begin
			if (!scan_hit && it.idx >= WIN_LO && it.idx < WIN_HI && it.rng <= cfg_max
				&& it.rng >= cfg_min && it.rng != 0) begin
				closing = -longint'(cur_speed) * beam_cosine(it.idx);
				// compare in q22 instead of dividing range by closing rate
				if (closing > 0 && (longint'(it.rng) <<< 22) < longint'(cfg_ttc) * closing) begin
					hit.brake = 1'b1;
					hit.idx   = it.idx;
					hit.rng   = it.rng;
					pending_brakes.push_back(hit);
					scan_hit = 1'b1;
				end
			end
			if (it.last) begin
				scan_hit = 1'b0;
			end
		end
	endtask

	task automatic send_item(input beam_item_t it);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 16) begin
			beam_ch.valid <= 1'b0;
			@(negedge clk);
		end
		beam_ch.valid      <= 1'b1;
		beam_ch.op         <= it.op;
		beam_ch.speed      <= it.speed;
		beam_ch.beam_index <= it.idx;
		beam_ch.range      <= it.rng;
		beam_ch.last_beam  <= it.last;
		do @(posedge clk); while (!beam_ch.ready);
		predict_brake(it);
	endtask

	function automatic beam_item_t beam(input int idx, input int rng, input bit last);
		beam_item_t it;
		it.op    = OP_BEAM;
		it.speed = 16'($urandom_range(0, 65535));
		it.idx   = IDX_W'(idx);
		it.rng   = RNG_W'(rng);
		it.last  = last;
		return it;
	endfunction

	function automatic beam_item_t speed_item(input logic [SPD_W-1:0] sp);
		beam_item_t it;
		it.op    = OP_SPEED;
		it.speed = sp;
		it.idx   = IDX_W'($urandom_range(0, 1023));
		it.rng   = RNG_W'($urandom_range(0, 65535));
		it.last  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// wait out every pending hit plus the beam pipeline before touching registers
	task automatic settle();
		@(negedge clk);
		beam_ch.valid <= 1'b0;
		while (pending_brakes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] reg_id, input logic [CFG_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_id, 2'b00};
		pwdata  <= APB_DW'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (reg_id)
			REG_TTC: cfg_ttc = val;
			REG_MAX: cfg_max = val;
			REG_MIN: cfg_min = val;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_limits(input int ttc, input int rmax, input int rmin);
		settle();
		apb_write(REG_TTC, CFG_W'(ttc));
		apb_write(REG_MAX, CFG_W'(rmax));
		apb_write(REG_MIN, CFG_W'(rmin));
	endtask

	function automatic logic [SPD_W-1:0] pick_speed();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return SPD_W'($urandom_range(0, 65535));
		end else if (r == 1) begin
			return SPD_W'(-int'($urandom_range(1, 32768)));
		end
		return SPD_W'($urandom_range(1, 5000));
	endfunction

	// ranges cluster around the braking distance for the current speed
	function automatic logic [RNG_W-1:0] pick_range();
		longint crit;
		longint hi;
		if ($urandom_range(0, 4) == 0) begin
			return RNG_W'($urandom_range(0, 65535));
		end
		crit = (longint'(cfg_ttc) * (cur_speed < 0 ? -longint'(cur_speed) : longint'(cur_speed)))
			>>> 8;
		hi = 2 * crit + 4;
		if (hi > 65535) begin
			hi = 65535;
		end
		return RNG_W'($urandom_range(0, int'(hi)));
	endfunction

	task automatic send_scans(input int n);
		int               sent;
		int               len;
		int               stride;
		logic [IDX_W-1:0] idx;
		beam_item_t       it;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 8) begin
				// noise transaction
				it.op    = 1'($urandom_range(0, 1));
				it.speed = SPD_W'($urandom_range(0, 65535));
				it.idx   = IDX_W'($urandom_range(0, 1023));
				it.rng   = RNG_W'($urandom_range(0, 65535));
				it.last  = 1'($urandom_range(0, 1));
				send_item(it);
				sent++;
			end else begin
				if ($urandom_range(0, 9) < 7) begin
					send_item(speed_item(pick_speed()));
					sent++;
				end
				len    = $urandom_range(1, 12);
				stride = $urandom_range(1, 10);
				idx    = IDX_W'($urandom_range(420, 640));
				for (int b = 0; b < len; b++) begin
					if ($urandom_range(0, 19) == 0) begin
						send_item(speed_item(pick_speed()));
						sent++;
					end
					// now and then the scan end mark goes missing
					send_item(beam(idx, pick_range(),
						(b == len - 1) && $urandom_range(0, 9) != 0));
					sent++;
					idx = idx + IDX_W'(stride);
				end
			end
		end
	endtask

	task automatic test_reset_defaults();
		// threshold resets to zero, so nothing may brake
		send_item(speed_item(16'sd32767));
		send_item(beam(500, 1, 1'b0));
		send_item(beam(600, 100, 1'b1));
	endtask

	task automatic test_directed();
		set_limits(256, 65535, 0);
		send_item(speed_item(16'd2000));
		send_item(beam(449, 100, 1'b0));
		send_item(beam(630, 100, 1'b0));
		send_item(beam(450, 0, 1'b0));
		send_item(beam(450, 100, 1'b0));
		send_item(beam(500, 50, 1'b0));
		send_item(beam(1023, 100, 1'b1));
		send_item(beam(629, 1, 1'b0));
		send_item(beam(600, 5, 1'b1));
		send_item(beam(540, 65535, 1'b0));
		send_item(speed_item(16'h8000));
		send_item(beam(540, 10, 1'b0));
		send_item(speed_item(16'd0));
		send_item(beam(540, 10, 1'b0));
		send_item(speed_item(16'h7fff));
		send_item(beam(560, 30000, 1'b1));
		send_item(beam(561, 30000, 1'b0));
		send_item(beam(0, 0, 1'b1));
	endtask

	task automatic test_range_limits();
		set_limits(256, 1000, 500);
		send_item(speed_item(16'd2000));
		send_item(beam(500, 499, 1'b1));
		send_item(beam(500, 500, 1'b1));
		send_item(beam(500, 1000, 1'b1));
		send_item(beam(500, 1001, 1'b1));
		// min above max blocks every beam
		set_limits(256, 1000, 2000);
		send_item(beam(500, 1500, 1'b1));
	endtask

	task automatic test_random_phase(input int ttc, input int rmax, input int rmin,
		input int n, input bit quiet);
		set_limits(ttc, rmax, rmin);
		steady = quiet;
		send_scans(n);
		steady = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && brake_ch.valid && brake_ch.ready) begin
			if (pending_brakes.size() == 0) begin
				note_mismatch($sformatf("unexpected brake idx %0d range %0d",
					brake_ch.hit_index, brake_ch.hit_range));
			end else begin
				want = pending_brakes.pop_front();
				if (brake_ch.brake !== want.brake) begin
					note_mismatch($sformatf("brake exp %0b got %0b", want.brake, brake_ch.brake));
				end
				if (brake_ch.hit_index !== want.idx) begin
					note_mismatch($sformatf("hit_index exp %0d got %0d", want.idx,
						brake_ch.hit_index));
				end
				if (brake_ch.hit_range !== want.rng) begin
					note_mismatch($sformatf("hit_range exp %0d got %0d", want.rng,
						brake_ch.hit_range));
				end
			end
		end
	end

	always @(negedge clk) begin
		brake_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 16);
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		beam_ch.valid      = 1'b0;
		beam_ch.op         = OP_SPEED;
		beam_ch.speed      = '0;
		beam_ch.beam_index = '0;
		beam_ch.range      = '0;
		beam_ch.last_beam  = 1'b0;
		brake_ch.ready     = 1'b0;
		steady             = 1'b0;
		err_count          = 0;
		cur_speed          = '0;
		scan_hit           = 1'b0;
		cfg_ttc            = '0;
		cfg_max            = 16'hffff;
		cfg_min            = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_directed();
		test_range_limits();
		test_random_phase(256, 65535, 0, 400, 1'b0);
		test_random_phase(65535, 65535, 0, 200, 1'b0);
		test_random_phase(1, 65535, 0, 150, 1'b0);
		test_random_phase(2048, 20000, 300, 400, 1'b1);
		test_random_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), 200, 1'b0);
		test_random_phase(0, 0, 0, 100, 1'b0);
		test_random_phase(777, 65535, 65535, 100, 1'b0);
		test_random_phase(512, 65535, 0, 100, 1'b0);
		settle();

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
